>>> design/rsch_pkg.sv
package rsch_pkg;

   // Register map, index i at byte address 4*i
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_CENTER_X = 3'd0;
   localparam logic [2:0] REG_CENTER_Y = 3'd1;
   localparam logic [2:0] REG_CENTER_Z = 3'd2;
   localparam logic [2:0] REG_RADIUS   = 3'd3;
   localparam logic [2:0] REG_THRESH   = 3'd4;
   localparam logic [2:0] REG_COLOR    = 3'd5;

   localparam logic [30:0] RADIUS_RESET = 31'd65536;

   // Root widths of the two square root chains
   localparam int SQ1_N = 50;
   localparam int SQ2_N = 55;
   // Quotient bits of the normal divider
   localparam int DIV_STEPS = 16;
   // Register stages before and between the root chains
   localparam int PRE_STAGES  = 6;
   localparam int POST_STAGES = 7;
   localparam int PIPE_LATENCY = PRE_STAGES + SQ1_N + POST_STAGES + SQ2_N + DIV_STEPS + 1;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [15:0] dir_x;
      logic signed [15:0] dir_y;
      logic signed [15:0] dir_z;
   } rsch_req_type;

   typedef struct packed {
      logic               hit;
      logic [30:0]        hit_distance;
      logic [23:0]        hit_color;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
   } rsch_rsp_type;

endpackage

>>> design/rsch_isqrt.sv
// Pipelined floor square root, one root bit per stage, with side data
module rsch_isqrt #(
   parameter int N  = 50,
   parameter int SW = 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [2*N-1:0]  in_rad,
   input  logic [SW-1:0]   in_side,
   output logic            out_valid,
   output logic [N-1:0]    out_root,
   output logic [SW-1:0]   out_side
);

   logic           valid_ff [0:N-1];
   logic [N+1:0]   rem_ff   [0:N-1];
   logic [N-1:0]   root_ff  [0:N-1];
   logic [2*N-1:0] rad_ff   [0:N-1];
   logic [SW-1:0]  side_ff  [0:N-1];

   for (genvar k = 0; k < N; k++) begin : g_step
      logic           valid_prev;
      logic [N+1:0]   rem_prev;
      logic [N-1:0]   root_prev;
      logic [2*N-1:0] rad_prev;
      logic [SW-1:0]  side_prev;
      logic [N+1:0]   rem_sh;
      logic [N+1:0]   trial;
      logic           take;
      logic [N+1:0]   rem_in;
      logic [N-1:0]   root_in;
      logic [2*N-1:0] rad_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = in_rad;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign rad_prev   = rad_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      // bring down two radicand bits, try the next root bit
      always_comb begin
         rem_sh  = {rem_prev[N-1:0], rad_prev[2*N-1 -: 2]};
         trial   = {root_prev, 2'b01};
         take    = (rem_sh >= trial);
         rem_in  = take ? (rem_sh - trial) : rem_sh;
         root_in = {root_prev[N-2:0], take};
         rad_in  = {rad_prev[2*N-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         rad_ff[k]  <= rad_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

>>> design/ray_sphere_closest_hit.sv
// Channel   Ports                              Handshake
// request   start, busy, req_data              taken when start and not busy
// response  rsp_strobe, rsp_data               one cycle per result, no back-pressure
// config    psel penable pwrite paddr pwdata   APB write, prdata read, pready tied high
//
// One ray enters per cycle; busy is never raised.
// Each result passes six setup stages, a 50-stage discriminant root, seven normal stages,
// a 55-stage length root, a 16-stage divider and the output register.
// Synchronous reset empties the pipeline and restores the register defaults.
// Registers are read live, so the user must change them only while the pipeline is empty;
// nothing in the block enforces this.
module ray_sphere_closest_hit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  rsch_pkg::rsch_req_type             req_data,
   output logic                               rsp_strobe,
   output rsch_pkg::rsch_rsp_type             rsp_data,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [rsch_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);
   import rsch_pkg::*;

   localparam int NM_W = SQ2_N;

   typedef struct packed {
      logic [2:0][32:0] d;
      logic [2:0][15:0] dir;
   } geo_type;

   localparam int SIDE1_W = 1 + 51 + $bits(geo_type);
   localparam int SIDE2_W = 1 + 31 + 3 + 3 * NM_W;

   // ---------------- configuration registers ----------------
   logic [31:0] center_ff [0:2];
   logic [30:0] radius_ff;
   logic [31:0] thresh_ff;
   logic [23:0] color_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[CSR_ADDR_W-1:2];

   // write on the access cycle, drop indexes past the list
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
         radius_ff    <= RADIUS_RESET;
         thresh_ff    <= '0;
         color_ff     <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_CENTER_X: center_ff[0] <= pwdata;
            REG_CENTER_Y: center_ff[1] <= pwdata;
            REG_CENTER_Z: center_ff[2] <= pwdata;
            REG_RADIUS:   radius_ff    <= pwdata[30:0];
            REG_THRESH:   thresh_ff    <= pwdata;
            REG_COLOR:    color_ff     <= pwdata[23:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_CENTER_X: prdata = center_ff[0];
         REG_CENTER_Y: prdata = center_ff[1];
         REG_CENTER_Z: prdata = center_ff[2];
         REG_RADIUS:   prdata = {1'b0, radius_ff};
         REG_THRESH:   prdata = thresh_ff;
         REG_COLOR:    prdata = {8'd0, color_ff};
         default:      prdata = '0;
      endcase
   end

   assign busy = 1'b0;

   // ---------------- stage 1: offset from the centre ----------------
   logic [31:0] org [0:2];
   logic [15:0] udir [0:2];
   assign org[0]  = req_data.origin_x;
   assign org[1]  = req_data.origin_y;
   assign org[2]  = req_data.origin_z;
   assign udir[0] = req_data.dir_x;
   assign udir[1] = req_data.dir_y;
   assign udir[2] = req_data.dir_z;

   logic    v1_ff;
   geo_type geo1_ff, geo1_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         geo1_in.d[i]   = {org[i][31], org[i]} - {center_ff[i][31], center_ff[i]};
         geo1_in.dir[i] = udir[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      geo1_ff <= geo1_in;
   end

   // ---------------- stage 2: squares and dot terms ----------------
   logic        v2_ff;
   geo_type     geo2_ff;
   logic [65:0] dd2_ff [0:2];
   logic [65:0] dd2_in [0:2];
   logic [48:0] db2_ff [0:2];
   logic [48:0] db2_in [0:2];
   logic [61:0] r2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd2_in[i] = 66'($signed(geo1_ff.d[i]) * $signed(geo1_ff.d[i]));
         db2_in[i] = 49'($signed(geo1_ff.d[i]) * $signed(geo1_ff.dir[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      geo2_ff <= geo1_ff;
      dd2_ff  <= dd2_in;
      db2_ff  <= db2_in;
      r2_ff   <= 62'(radius_ff * radius_ff);
   end

   // ---------------- stage 3: c and b ----------------
   logic        v3_ff;
   geo_type     geo3_ff;
   logic [68:0] dsum3_ff;
   logic [50:0] b3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      geo3_ff  <= geo2_ff;
      dsum3_ff <= {3'd0, dd2_ff[0]} + {3'd0, dd2_ff[1]} + {3'd0, dd2_ff[2]}
                  - {7'd0, r2_ff};
      b3_ff    <= {{2{db2_ff[0][48]}}, db2_ff[0]} + {{2{db2_ff[1][48]}}, db2_ff[1]}
                  + {{2{db2_ff[2][48]}}, db2_ff[2]};
   end

   // ---------------- stage 4: partial products of b squared ----------------
   logic        v4_ff;
   geo_type     geo4_ff;
   logic [68:0] dsum4_ff;
   logic [50:0] b4_ff;
   logic [49:0] bhh_ff, bhl_ff, bll_ff;
   logic [50:0] bneg;
   logic [49:0] bmag;

   assign bneg = -b3_ff;
   assign bmag = b3_ff[50] ? bneg[49:0] : b3_ff[49:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      geo4_ff  <= geo3_ff;
      dsum4_ff <= dsum3_ff;
      b4_ff    <= b3_ff;
      bhh_ff   <= bmag[49:25] * bmag[49:25];
      bhl_ff   <= bmag[49:25] * bmag[24:0];
      bll_ff   <= bmag[24:0] * bmag[24:0];
   end

   // ---------------- stage 5: b squared ----------------
   logic        v5_ff;
   geo_type     geo5_ff;
   logic [68:0] dsum5_ff;
   logic [50:0] b5_ff;
   logic [99:0] bsq5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      geo5_ff  <= geo4_ff;
      dsum5_ff <= dsum4_ff;
      b5_ff    <= b4_ff;
      bsq5_ff  <= {bhh_ff, 50'd0} + {24'd0, bhl_ff, 26'd0} + {50'd0, bll_ff};
   end

   // ---------------- stage 6: discriminant ----------------
   logic         v6_ff;
   geo_type      geo6_ff;
   logic [50:0]  b6_ff;
   logic [100:0] t6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else begin
         v6_ff <= v5_ff;
      end
      geo6_ff <= geo5_ff;
      b6_ff   <= b5_ff;
      t6_ff   <= {1'b0, bsq5_ff} - {{4{dsum5_ff[68]}}, dsum5_ff, 28'd0};
   end

   // miss on a negative discriminant or one under the threshold
   logic [100:0] thr101;
   logic         miss6;
   assign thr101 = {{25{thresh_ff[31]}}, thresh_ff, 44'd0};
   assign miss6  = t6_ff[100] || ($signed(t6_ff) < $signed(thr101));

   // ---------------- discriminant root ----------------
   logic               sq1_valid;
   logic [SQ1_N-1:0]   sq1_root;
   logic [SIDE1_W-1:0] sq1_side;

   rsch_isqrt #(.N(SQ1_N), .SW(SIDE1_W)) u_sqrt_disc (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v6_ff),
      .in_rad   (t6_ff[2*SQ1_N-1:0]),
      .in_side  ({miss6, b6_ff, geo6_ff}),
      .out_valid(sq1_valid),
      .out_root (sq1_root),
      .out_side (sq1_side)
   );

   logic        miss_r;
   logic [50:0] b_r;
   geo_type     geo_r;
   assign {miss_r, b_r, geo_r} = sq1_side;

   // ---------------- stage 8: nearer positive root ----------------
   logic        v8_ff, miss8_ff, miss8_in;
   geo_type     geo8_ff;
   logic [52:0] tq8_ff, tq8_in, nb, tqa, tqb;

   always_comb begin
      nb  = -{{2{b_r[50]}}, b_r};
      tqa = nb - {3'd0, sq1_root};
      tqb = nb + {3'd0, sq1_root};
      if (!tqa[52] && (tqa != '0)) begin
         tq8_in   = tqa;
         miss8_in = miss_r;
      end else begin
         tq8_in   = tqb;
         miss8_in = miss_r || tqb[52] || (tqb == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= sq1_valid;
      end
      geo8_ff  <= geo_r;
      tq8_ff   <= tq8_in;
      miss8_ff <= miss8_in;
   end

   // ---------------- stage 9: round to Q16.16, saturate ----------------
   logic        v9_ff, miss9_ff;
   geo_type     geo9_ff;
   logic [38:0] t16_9_ff;
   logic [30:0] dist9_ff;
   logic [52:0] tq_rnd;

   assign tq_rnd = tq8_ff + 53'd8192;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= v8_ff;
      end
      geo9_ff  <= geo8_ff;
      miss9_ff <= miss8_ff;
      t16_9_ff <= tq_rnd[52:14];
      dist9_ff <= (tq_rnd[52:45] != '0) ? 31'h7FFF_FFFF : tq_rnd[44:14];
   end

   // ---------------- stage 10: distance times direction ----------------
   logic        v10_ff, miss10_ff;
   logic [30:0] dist10_ff;
   logic [32:0] d10_ff    [0:2];
   logic [55:0] prod10_ff [0:2];
   logic [55:0] prod10_in [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod10_in[i] = 56'($signed({1'b0, t16_9_ff}) * $signed(geo9_ff.dir[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else begin
         v10_ff <= v9_ff;
      end
      miss10_ff <= miss9_ff;
      dist10_ff <= dist9_ff;
      for (int i = 0; i < 3; i++) begin
         d10_ff[i] <= geo9_ff.d[i];
      end
      prod10_ff <= prod10_in;
   end

   // ---------------- stage 11: normal vector, split sign ----------------
   logic            v11_ff, miss11_ff;
   logic [30:0]     dist11_ff;
   logic [2:0]      sgn11_ff, sgn11_in;
   logic [NM_W-1:0] mag11_ff [0:2];
   logic [NM_W-1:0] mag11_in [0:2];
   logic [55:0]     nvec     [0:2];
   logic [55:0]     nneg     [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         nvec[i]     = {{9{d10_ff[i][32]}}, d10_ff[i], 14'd0} + prod10_ff[i];
         nneg[i]     = -nvec[i];
         sgn11_in[i] = nvec[i][55];
         mag11_in[i] = nvec[i][55] ? nneg[i][NM_W-1:0] : nvec[i][NM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v11_ff <= 1'b0;
      end else begin
         v11_ff <= v10_ff;
      end
      miss11_ff <= miss10_ff;
      dist11_ff <= dist10_ff;
      sgn11_ff  <= sgn11_in;
      mag11_ff  <= mag11_in;
   end

   // ---------------- stage 12: partial products of the squares ----------------
   logic            v12_ff, miss12_ff;
   logic [30:0]     dist12_ff;
   logic [2:0]      sgn12_ff;
   logic [NM_W-1:0] mag12_ff [0:2];
   logic [55:0]     nhh_ff   [0:2];
   logic [54:0]     nhl_ff   [0:2];
   logic [53:0]     nll_ff   [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v12_ff <= 1'b0;
      end else begin
         v12_ff <= v11_ff;
      end
      miss12_ff <= miss11_ff;
      dist12_ff <= dist11_ff;
      sgn12_ff  <= sgn11_ff;
      mag12_ff  <= mag11_ff;
      for (int i = 0; i < 3; i++) begin
         nhh_ff[i] <= mag11_ff[i][54:27] * mag11_ff[i][54:27];
         nhl_ff[i] <= mag11_ff[i][54:27] * mag11_ff[i][26:0];
         nll_ff[i] <= mag11_ff[i][26:0] * mag11_ff[i][26:0];
      end
   end

   // ---------------- stage 13: component squares ----------------
   logic            v13_ff, miss13_ff;
   logic [30:0]     dist13_ff;
   logic [2:0]      sgn13_ff;
   logic [NM_W-1:0] mag13_ff [0:2];
   logic [109:0]    sq13_ff  [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v13_ff <= 1'b0;
      end else begin
         v13_ff <= v12_ff;
      end
      miss13_ff <= miss12_ff;
      dist13_ff <= dist12_ff;
      sgn13_ff  <= sgn12_ff;
      mag13_ff  <= mag12_ff;
      for (int i = 0; i < 3; i++) begin
         sq13_ff[i] <= {nhh_ff[i], 54'd0} + {27'd0, nhl_ff[i], 28'd0} + {56'd0, nll_ff[i]};
      end
   end

   // ---------------- stage 14: squared length ----------------
   logic            v14_ff, miss14_ff;
   logic [30:0]     dist14_ff;
   logic [2:0]      sgn14_ff;
   logic [NM_W-1:0] mag14_ff [0:2];
   logic [109:0]    nsum14_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v14_ff <= 1'b0;
      end else begin
         v14_ff <= v13_ff;
      end
      miss14_ff <= miss13_ff;
      dist14_ff <= dist13_ff;
      sgn14_ff  <= sgn13_ff;
      mag14_ff  <= mag13_ff;
      nsum14_ff <= sq13_ff[0] + sq13_ff[1] + sq13_ff[2];
   end

   // ---------------- normal length root ----------------
   logic               sq2_valid;
   logic [SQ2_N-1:0]   sq2_root;
   logic [SIDE2_W-1:0] sq2_side;

   rsch_isqrt #(.N(SQ2_N), .SW(SIDE2_W)) u_sqrt_len (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v14_ff),
      .in_rad   (nsum14_ff[2*SQ2_N-1:0]),
      .in_side  ({miss14_ff, dist14_ff, sgn14_ff, mag14_ff[2], mag14_ff[1], mag14_ff[0]}),
      .out_valid(sq2_valid),
      .out_root (sq2_root),
      .out_side (sq2_side)
   );

   logic            miss_l;
   logic [30:0]     dist_l;
   logic [2:0]      sgn_l;
   logic [NM_W-1:0] mag_l [0:2];
   assign {miss_l, dist_l, sgn_l, mag_l[2], mag_l[1], mag_l[0]} = sq2_side;

   // ---------------- divider: one quotient bit per stage ----------------
   logic                 dv_ff    [0:DIV_STEPS-1];
   logic                 dmiss_ff [0:DIV_STEPS-1];
   logic [30:0]          ddist_ff [0:DIV_STEPS-1];
   logic [2:0]           dsgn_ff  [0:DIV_STEPS-1];
   logic [NM_W-1:0]      dlen_ff  [0:DIV_STEPS-1];
   logic [NM_W:0]        drem_ff  [0:DIV_STEPS-1][0:2];
   logic [DIV_STEPS-1:0] dq_ff    [0:DIV_STEPS-1][0:2];

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      logic            v_prev, miss_prev;
      logic [30:0]     dist_prev;
      logic [2:0]      sgn_prev;
      logic [NM_W-1:0] len_prev;

      if (k == 0) begin : g_first
         assign v_prev    = sq2_valid;
         assign miss_prev = miss_l;
         assign dist_prev = dist_l;
         assign sgn_prev  = sgn_l;
         assign len_prev  = sq2_root;
      end else begin : g_next
         assign v_prev    = dv_ff[k-1];
         assign miss_prev = dmiss_ff[k-1];
         assign dist_prev = ddist_ff[k-1];
         assign sgn_prev  = dsgn_ff[k-1];
         assign len_prev  = dlen_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else begin
            dv_ff[k] <= v_prev;
         end
         dmiss_ff[k] <= miss_prev;
         ddist_ff[k] <= dist_prev;
         dsgn_ff[k]  <= sgn_prev;
         dlen_ff[k]  <= len_prev;
      end

      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic [NM_W:0]        rsh, rem_in;
         logic [DIV_STEPS-1:0] q_prev, q_in;
         logic                 take;

         if (k == 0) begin : g_first
            assign rsh    = {1'b0, mag_l[l]};
            assign q_prev = '0;
         end else begin : g_next
            assign rsh    = {drem_ff[k-1][l][NM_W-1:0], 1'b0};
            assign q_prev = dq_ff[k-1][l];
         end

         // subtract the length where it fits, shift in the quotient bit
         always_comb begin
            take   = (rsh >= {1'b0, len_prev});
            rem_in = take ? (rsh - {1'b0, len_prev}) : rsh;
            q_in   = {q_prev[DIV_STEPS-2:0], take};
         end

         always_ff @(posedge clock) begin
            drem_ff[k][l] <= rem_in;
            dq_ff[k][l]   <= q_in;
         end
      end
   end

   // ---------------- output: round, apply sign, zero a miss or a zero-length normal ----------------
   logic                 rsp_strobe_ff;
   rsch_rsp_type         rsp_data_ff, rsp_data_in;
   logic [DIV_STEPS:0]   qr   [0:2];
   logic [15:0]          comp [0:2];
   logic                 len_zero;

   always_comb begin
      len_zero = (dlen_ff[DIV_STEPS-1] == '0);
      for (int i = 0; i < 3; i++) begin
         qr[i]   = ({1'b0, dq_ff[DIV_STEPS-1][i]} + 17'd1) >> 1;
         comp[i] = dsgn_ff[DIV_STEPS-1][i] ? -qr[i][15:0] : qr[i][15:0];
         if (len_zero) begin
            comp[i] = '0;
         end
      end
      rsp_data_in = '0;
      if (!dmiss_ff[DIV_STEPS-1]) begin
         rsp_data_in.hit          = 1'b1;
         rsp_data_in.hit_distance = ddist_ff[DIV_STEPS-1];
         rsp_data_in.hit_color    = color_ff;
         rsp_data_in.normal_x     = comp[0];
         rsp_data_in.normal_y     = comp[1];
         rsp_data_in.normal_z     = comp[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= dv_ff[DIV_STEPS-1];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

>>> design/rsch_checker.sv
module rsch_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input rsch_pkg::rsch_rsp_type rsp_data
);
   import rsch_pkg::*;

   // every accepted transaction yields a result after the fixed latency
   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##PIPE_LATENCY rsp_strobe)
      else $error("accepted transaction produced no result");

   // no result without a transaction accepted the latency before
   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, PIPE_LATENCY))
      else $error("result without a matching transaction");

   // a miss carries all-zero fields
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.hit) |-> (rsp_data.hit_distance == '0 &&
         rsp_data.hit_color == '0 && rsp_data.normal_x == '0 &&
         rsp_data.normal_y == '0 && rsp_data.normal_z == '0))
      else $error("miss with nonzero fields");

   // unit normal components stay within one
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.hit) |->
         ($signed(rsp_data.normal_x) <= 16384 && $signed(rsp_data.normal_x) >= -16384 &&
          $signed(rsp_data.normal_y) <= 16384 && $signed(rsp_data.normal_y) >= -16384 &&
          $signed(rsp_data.normal_z) <= 16384 && $signed(rsp_data.normal_z) >= -16384))
      else $error("normal component out of range");

endmodule

bind ray_sphere_closest_hit rsch_checker u_rsch_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

>>> bench/ray_sphere_closest_hit_tb.sv
module ray_sphere_closest_hit_tb;
   import rsch_pkg::*;

   typedef struct {
      rsch_req_type ray;
      bit           pinned;
      rsch_rsp_type rsp;
   } ray_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   rsch_req_type req_data = '0;
   logic         rsp_strobe;
   rsch_rsp_type rsp_data;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   // Shadow copy of the sphere registers
   logic signed [31:0] sph_center [3];
   logic [30:0]        sph_radius;
   logic signed [31:0] sph_thresh;
   logic [23:0]        sph_color;

   rsch_rsp_type hit_queue [$];
   bit           ray_pinned = 1'b0;
   rsch_rsp_type ray_pinned_rsp = '0;
   bit           no_gaps = 1'b0;
   int           fail_count = 0;
   int           cycle_count = 0;
   int           rays_sent = 0;
   int           hits_seen = 0;
   int           misses_seen = 0;
   ray_row_type  ray_table [$];

   ray_sphere_closest_hit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .psel(psel), .penable(penable),
      .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #1 clock = ~clock;

   // Floor square root of a non-negative 128-bit value below 2**126
   function automatic logic [63:0] floor_sqrt(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int k = 62; k >= 0; k--) begin
         c = r | (64'd1 << k);
         if ({64'd0, c} * {64'd0, c} <= v) r = c;
      end
      return r;
   endfunction

   // Compute the closest hit of one ray against the shadow sphere
   function automatic rsch_rsp_type closest_hit(rsch_req_type ray);
      rsch_rsp_type       res;
      logic signed [31:0] org [3];
      logic signed [15:0] dir16 [3];
      logic signed [63:0] d [3];
      logic signed [63:0] dv [3];
      logic signed [63:0] n [3];
      logic signed [63:0] b, tq, t16, cen64;
      logic signed [127:0] dsum, disc, lim, nsum, rsq;
      logic [63:0]        s, len, mag_n;
      logic [127:0]       quo;
      logic [15:0]        comp;
      res = '0;
      org = '{ray.origin_x, ray.origin_y, ray.origin_z};
      dir16 = '{ray.dir_x, ray.dir_y, ray.dir_z};
      b = 0;
      dsum = 0;
      for (int i = 0; i < 3; i++) begin
         d[i] = org[i];
         cen64 = sph_center[i];
         d[i] = d[i] - cen64;
         dv[i] = dir16[i];
         b = b + d[i] * dv[i];
         dsum = dsum + 128'(d[i]) * 128'(d[i]);
      end
      rsq = $signed({97'd0, sph_radius}) * $signed({97'd0, sph_radius});
      dsum = dsum - rsq;
      disc = 128'(b) * 128'(b) - (dsum <<< 28);
      lim = sph_thresh;
      lim = lim <<< 44;
      if (disc < lim || disc < 0) return res;
      s = floor_sqrt(disc);
      tq = -b - $signed(s);
      if (tq <= 0) begin
         tq = -b + $signed(s);
         if (tq <= 0) return res;
      end
      t16 = (tq + 64'sd8192) >>> 14;
      res.hit = 1'b1;
      res.hit_distance = (t16 > 64'sh7FFFFFFF) ? 31'h7FFFFFFF : t16[30:0];
      res.hit_color = sph_color;
      nsum = 0;
      for (int i = 0; i < 3; i++) begin
         n[i] = d[i] * 64'sd16384 + t16 * dv[i];
         nsum = nsum + 128'(n[i]) * 128'(n[i]);
      end
      len = floor_sqrt(nsum);
      if (len != 0) begin
         for (int i = 0; i < 3; i++) begin
            mag_n = (n[i] < 0) ? 64'(-n[i]) : 64'(n[i]);
            quo = ({64'd0, mag_n} << 15) / {64'd0, len};
            comp = 16'((quo + 1) >> 1);
            if (n[i] < 0) comp = -comp;
            if (i == 0) res.normal_x = comp;
            else if (i == 1) res.normal_y = comp;
            else res.normal_z = comp;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h (t=%0t)", field, got, want, $time);
      fail_count++;
   endtask

   // Record accepted rays, check each result against the oldest expectation
   always @(posedge clock) begin
      rsch_rsp_type want;
      if (!reset && start && !busy) begin
         hit_queue.push_back(ray_pinned ? ray_pinned_rsp : closest_hit(req_data));
      end
      if (!reset && rsp_strobe) begin
         if (hit_queue.size() == 0) begin
            report_mismatch("unexpected transaction", 64'(rsp_data.hit), 64'd0);
         end else begin
            want = hit_queue.pop_front();
            if (rsp_data.hit) hits_seen++;
            else misses_seen++;
            if (rsp_data.hit !== want.hit)
               report_mismatch("hit", 64'(rsp_data.hit), 64'(want.hit));
            if (rsp_data.hit_distance !== want.hit_distance)
               report_mismatch("hit_distance", 64'(rsp_data.hit_distance),
                               64'(want.hit_distance));
            if (rsp_data.hit_color !== want.hit_color)
               report_mismatch("hit_color", 64'(rsp_data.hit_color), 64'(want.hit_color));
            if (rsp_data.normal_x !== want.normal_x)
               report_mismatch("normal_x", 64'(rsp_data.normal_x), 64'(want.normal_x));
            if (rsp_data.normal_y !== want.normal_y)
               report_mismatch("normal_y", 64'(rsp_data.normal_y), 64'(want.normal_y));
            if (rsp_data.normal_z !== want.normal_z)
               report_mismatch("normal_z", 64'(rsp_data.normal_z), 64'(want.normal_z));
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 400000) begin
         $display("[ray_sphere_closest_hit] ERROR");
         $finish;
      end
   end

   // Drive one ray and hold it until taken, then, unless no_gaps is set, idle each cycle at 31 percent
   task automatic send_ray(rsch_req_type ray, bit pinned, rsch_rsp_type rsp);
      req_data <= ray;
      start <= 1'b1;
      ray_pinned <= pinned;
      ray_pinned_rsp <= rsp;
      do @(posedge clock); while (busy);
      rays_sent++;
      if (!no_gaps) begin
         while ($urandom_range(99) < 31) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= CSR_ADDR_W'(idx) << 2;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_CENTER_X: sph_center[0] = value;
         REG_CENTER_Y: sph_center[1] = value;
         REG_CENTER_Z: sph_center[2] = value;
         REG_RADIUS:   sph_radius = value[30:0];
         REG_THRESH:   sph_thresh = value;
         REG_COLOR:    sph_color = value[23:0];
         default: ;
      endcase
   endtask

   // Drain the pipeline before touching the registers
   task automatic wait_drained();
      start <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic load_sphere(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] rad, logic [31:0] thr, logic [31:0] col);
      wait_drained();
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_CENTER_Z, cz);
      csr_write(REG_RADIUS, rad);
      csr_write(REG_THRESH, thr);
      csr_write(REG_COLOR, col);
   endtask

   // Mostly rays aimed near the sphere, the rest raw bit noise
   function automatic rsch_req_type random_ray();
      rsch_req_type ray;
      real c [3];
      real v [3];
      real rr, spread, len;
      longint o [3];
      if ($urandom_range(99) < 30) begin
         ray = {$urandom, $urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom)};
         return ray;
      end
      rr = real'(sph_radius) / 65536.0;
      spread = rr * 4.0 + 4.0;
      if (spread > 20000.0) spread = 20000.0;
      for (int i = 0; i < 3; i++) begin
         c[i] = real'(sph_center[i]) / 65536.0;
         o[i] = longint'(sph_center[i])
              + longint'($rtoi((real'($urandom_range(2000)) / 1000.0 - 1.0) * spread * 65536.0));
         v[i] = c[i] + (real'($urandom_range(2000)) / 1000.0 - 1.0) * rr
              - real'(o[i]) / 65536.0;
      end
      len = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
      if (len < 1.0e-6) begin
         v = '{1.0, 0.0, 0.0};
         len = 1.0;
      end
      ray.origin_x = o[0][31:0];
      ray.origin_y = o[1][31:0];
      ray.origin_z = o[2][31:0];
      ray.dir_x = 16'($rtoi(v[0] / len * 16384.0));
      ray.dir_y = 16'($rtoi(v[1] / len * 16384.0));
      ray.dir_z = 16'($rtoi(v[2] / len * 16384.0));
      return ray;
   endfunction

   task automatic random_rays(int count);
      for (int i = 0; i < count; i++) send_ray(random_ray(), 1'b0, '0);
   endtask

   task automatic add_row(rsch_req_type ray, bit pinned, rsch_rsp_type rsp);
      ray_row_type row;
      row.ray = ray;
      row.pinned = pinned;
      row.rsp = rsp;
      ray_table.push_back(row);
   endtask

   initial begin
      rsch_rsp_type miss;
      miss = '0;
      sph_center = '{0, 0, 0};
      sph_radius = RADIUS_RESET;
      sph_thresh = 0;
      sph_color = '0;

      // Directed rays at the reset sphere (unit sphere at origin)
      add_row('{0, 0, 32'hFFFD0000, 16'sd0, 16'sd0, 16'sd16384}, 1'b1,
              '{1'b1, 31'd131072, 24'd0, 16'sd0, 16'sd0, -16'sd16384});
      add_row('{0, 0, 32'hFFFD0000, 16'sd0, 16'sd0, -16'sd16384}, 1'b1, miss);
      add_row('{0, 0, 0, 16'sd16384, 16'sd0, 16'sd0}, 1'b1,
              '{1'b1, 31'd65536, 24'd0, 16'sd16384, 16'sd0, 16'sd0});
      add_row('{0, 0, 0, 16'sd0, 16'sd0, 16'sd0}, 1'b1,
              '{1'b1, 31'd65536, 24'd0, 16'sd0, 16'sd0, 16'sd0});
      add_row('{0, 32'h00018000, 32'hFFFD0000, 16'sd0, 16'sd0, 16'sd16384}, 1'b1, miss);
      add_row('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, -16'sd32768, -16'sd32768,
                -16'sd32768}, 1'b0, miss);
      add_row('{32'h80000000, 32'h80000000, 32'h80000000, 16'sd32767, 16'sd32767,
                16'sd32767}, 1'b0, miss);
      add_row('{32'h80000000, 0, 32'h7FFFFFFF, 16'sd32767, -16'sd32768, 16'sd0}, 1'b0, miss);
      add_row('{0, 0, 0, -16'sd32768, 16'sd0, 16'sd32767}, 1'b0, miss);
      add_row('{32'h00008000, 32'hFFFF8000, 32'h00020000, 16'sd0, 16'sd11585,
                -16'sd11585}, 1'b0, miss);
      add_row('{32'hFFFE0000, 32'h00004000, 0, 16'sd16384, 16'sd0, 16'sd0}, 1'b0, miss);
      add_row('{0, 0, 32'h00010000, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, miss);
      add_row('{0, 0, 0, 16'sd1, 16'sd0, 16'sd0}, 1'b0, miss);

      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (ray_table[i]) send_ray(ray_table[i].ray, ray_table[i].pinned, ray_table[i].rsp);
      random_rays(60);

      load_sphere(32'h00010000, 32'hFFFE0000, 32'h00050000, 32'h00028000, 0, 32'h00FFFFFF);
      random_rays(100);

      // Unit sphere, negative threshold: grazing rays with small negative discriminant
      load_sphere(32'hFF9B8000, 32'h00254000, 32'h000C0000, 32'h00010000, 32'hFFFE0000,
                  32'h00123456);
      no_gaps = 1'b1;
      send_ray('{32'hFF9B8000, 32'h0026C000, 32'h00090000, 16'sd0, 16'sd0, 16'sd16384},
               1'b1, miss);
      random_rays(100);
      no_gaps = 1'b0;

      load_sphere(32'h7FFFFFFF, 32'h80000000, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h00A5A5A5);
      random_rays(90);

      load_sphere(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 32'h80000000, 0);
      random_rays(90);

      // Far sphere: distance saturates
      load_sphere(0, 0, 32'h7D000000, 32'h03E80000, 0, 32'h005A5A5A);
      send_ray('{0, 0, 32'h83000000, 16'sd0, 16'sd0, 16'sd16384}, 1'b0, miss);
      random_rays(90);

      load_sphere(32'h00030000, 32'h00030000, 32'hFFFD0000, 32'h00004000, 32'h00010000,
                  32'h0000FF00);
      random_rays(100);

      start <= 1'b0;
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);

      $display("rays sent %0d over 7 sphere settings: %0d hits, %0d misses, %0d mismatches",
               rays_sent, hits_seen, misses_seen, fail_count);
      if (fail_count == 0) begin
         $display("[ray_sphere_closest_hit] OK");
      end else begin
         $display("[ray_sphere_closest_hit] ERROR");
      end
      $finish;
   end

endmodule

>>> ray_sphere_closest_hit.f
design/rsch_pkg.sv
design/rsch_isqrt.sv
design/ray_sphere_closest_hit.sv
design/rsch_checker.sv
bench/ray_sphere_closest_hit_tb.sv
